// ===== hw/rtl/rqsm_pkg.sv =====
package rqsm_pkg;

    // default sizes
    localparam int SLOT_COUNT_DEF       = 64;
    localparam int HANDLE_WIDTH_DEF     = 32;
    localparam int SKIP_COUNT_WIDTH_DEF = 16;

    // fixed field widths
    localparam int CFG_W    = 3;
    localparam int STATUS_W = 3;
    localparam int VALUE_W  = 32;
    localparam int KIND_W   = 2;

    localparam logic [CFG_W-1:0] SIZE_LOG2_RESET = 3'd6;

    // slot kinds
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SKIP  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_PUSHED    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_REJECTED  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_POPPED    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NONE      = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_SATURATED = 3'd4;

endpackage

// ===== hw/rtl/ring_queue_with_skip_marks_unit.sv =====
// a pop reads its slot from the slot memory, then in the lookup state writes the slot back and registers
// its result on m_; a push first walks over each skip-marked slot it meets, counting its mark down
// and writing it back, then registers its result; a new input beat is taken only in the idle state, so the
// block takes no new beat until the lookup has registered its result; a result still held on m_ makes it wait
// reset: synchronous, active low; afterwards a clearing pass walks the slots in index order and marks
// every slot empty, with s_ready held low (configuration writes are still taken)
module ring_queue_with_skip_marks_unit #(
    parameter int SLOT_COUNT       = rqsm_pkg::SLOT_COUNT_DEF,
    parameter int HANDLE_WIDTH     = rqsm_pkg::HANDLE_WIDTH_DEF,
    parameter int SKIP_COUNT_WIDTH = rqsm_pkg::SKIP_COUNT_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [rqsm_pkg::CFG_W-1:0]     cfg_wr_data,
    // input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_mode,
    input  logic [rqsm_pkg::VALUE_W-1:0]   s_entry_value,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rqsm_pkg::STATUS_W-1:0]  m_status,
    output logic [rqsm_pkg::VALUE_W-1:0]   m_popped_value
);
    import rqsm_pkg::*;

    localparam int IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int LOG_MAX = $clog2(SLOT_COUNT + 1) - 1;
    localparam int SLOT_W  = KIND_W + SKIP_COUNT_WIDTH;
    localparam logic [SKIP_COUNT_WIDTH-1:0] SKIP_MAX = {SKIP_COUNT_WIDTH{1'b1}};
    localparam logic [SKIP_COUNT_WIDTH-1:0] SKIP_ONE = SKIP_COUNT_WIDTH'(1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    // sequencer states
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;

    // slot memories
    logic [SLOT_W-1:0]       slot_mem   [SLOT_COUNT];
    logic [HANDLE_WIDTH-1:0] handle_mem [SLOT_COUNT];

    logic [1:0]              state_reg, state_next;
    logic [CFG_W-1:0]        size_log2_reg;
    logic [IDX_W-1:0]        wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]        cur_idx_reg, cur_idx_next;
    logic [IDX_W-1:0]        clr_idx_reg;
    logic                    mode_reg;
    logic [HANDLE_WIDTH-1:0] handle_reg;
    logic [SLOT_W-1:0]       rd_slot_reg;
    logic [HANDLE_WIDTH-1:0] rd_handle_reg;
    logic                    fwd_hit_reg, fwd_hit_next;
    logic [SLOT_W-1:0]       fwd_slot_reg;
    logic                    m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]     m_status_reg, m_status_next;
    logic [VALUE_W-1:0]      m_value_reg, m_value_next;

    logic [CFG_W-1:0]        eff_log2;
    logic [IDX_W:0]          size_one;
    logic [IDX_W-1:0]        idx_mask;
    logic [IDX_W-1:0]        next_idx;
    logic [SLOT_W-1:0]       cur_slot;
    logic [KIND_W-1:0]       cur_kind;
    logic [SKIP_COUNT_WIDTH-1:0] cur_cnt;
    logic                    out_free;
    logic                    accept;
    logic                    slot_we;
    logic [IDX_W-1:0]        slot_waddr;
    logic [SLOT_W-1:0]       slot_wdata;
    logic                    handle_we;

    // index mask from the clamped size
    always_comb begin
        if (int'(size_log2_reg) > LOG_MAX) begin
            eff_log2 = CFG_W'(LOG_MAX);
        end else begin
            eff_log2 = size_log2_reg;
        end
        size_one = ({{IDX_W{1'b0}}, 1'b1} << eff_log2) - 1'b1;
        idx_mask = size_one[IDX_W-1:0];
    end

    // slot seen this cycle, with forwarding of the last write-back
    assign cur_slot = fwd_hit_reg ? fwd_slot_reg : rd_slot_reg;
    assign cur_kind = cur_slot[SLOT_W-1 -: KIND_W];
    assign cur_cnt  = cur_slot[SKIP_COUNT_WIDTH-1:0];
    assign next_idx = (cur_idx_reg + 1'b1) & idx_mask;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // sequencer
    always_comb begin
        state_next    = state_reg;
        wr_idx_next   = wr_idx_reg;
        rd_idx_next   = rd_idx_reg;
        cur_idx_next  = cur_idx_reg;
        fwd_hit_next  = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        slot_we       = 1'b0;
        slot_waddr    = cur_idx_reg;
        slot_wdata    = {KIND_EMPTY, {SKIP_COUNT_WIDTH{1'b0}}};
        handle_we     = 1'b0;

        case (state_reg)
            S_CLEAR: begin
                slot_we    = 1'b1;
                slot_waddr = clr_idx_reg;
                if (clr_idx_reg == LAST_IDX) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    cur_idx_next = s_mode ? (rd_idx_reg & idx_mask) : (wr_idx_reg & idx_mask);
                    state_next   = S_LOOK;
                end
            end
            S_LOOK: begin
                if (!mode_reg) begin
                    // push walk
                    if (cur_kind == KIND_SKIP) begin
                        slot_we = 1'b1;
                        if (cur_cnt <= SKIP_ONE) begin
                            slot_wdata = {KIND_EMPTY, {SKIP_COUNT_WIDTH{1'b0}}};
                        end else begin
                            slot_wdata = {KIND_SKIP, cur_cnt - SKIP_ONE};
                        end
                        cur_idx_next = next_idx;
                        fwd_hit_next = (next_idx == cur_idx_reg);
                    end else if (out_free) begin
                        m_valid_next = 1'b1;
                        m_value_next = '0;
                        state_next   = S_IDLE;
                        if (cur_kind == KIND_FULL) begin
                            m_status_next = STAT_REJECTED;
                            wr_idx_next   = cur_idx_reg;
                        end else begin
                            slot_we       = 1'b1;
                            slot_wdata    = {KIND_FULL, {SKIP_COUNT_WIDTH{1'b0}}};
                            handle_we     = 1'b1;
                            m_status_next = STAT_PUSHED;
                            wr_idx_next   = next_idx;
                        end
                    end
                end else if (out_free) begin
                    // pop of one slot
                    m_valid_next = 1'b1;
                    m_value_next = '0;
                    rd_idx_next  = next_idx;
                    state_next   = S_IDLE;
                    if (cur_kind == KIND_FULL) begin
                        slot_we       = 1'b1;
                        slot_wdata    = {KIND_EMPTY, {SKIP_COUNT_WIDTH{1'b0}}};
                        m_status_next = STAT_POPPED;
                        m_value_next  = VALUE_W'(rd_handle_reg);
                    end else if (cur_kind == KIND_SKIP) begin
                        if (cur_cnt == SKIP_MAX) begin
                            m_status_next = STAT_SATURATED;
                        end else begin
                            slot_we       = 1'b1;
                            slot_wdata    = {KIND_SKIP, cur_cnt + SKIP_ONE};
                            m_status_next = STAT_NONE;
                        end
                    end else begin
                        slot_we       = 1'b1;
                        slot_wdata    = {KIND_SKIP, SKIP_ONE};
                        m_status_next = STAT_NONE;
                    end
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // slot memory: registered read at the next lookup index, write back
    always_ff @(posedge aclk) begin
        rd_slot_reg <= slot_mem[cur_idx_next];
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
    end

    // handle memory
    always_ff @(posedge aclk) begin
        rd_handle_reg <= handle_mem[cur_idx_next];
        if (handle_we) begin
            handle_mem[cur_idx_reg] <= handle_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            size_log2_reg <= SIZE_LOG2_RESET;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            cur_idx_reg   <= '0;
            clr_idx_reg   <= '0;
            fwd_hit_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wr_idx_reg  <= wr_idx_next;
            rd_idx_reg  <= rd_idx_next;
            cur_idx_reg <= cur_idx_next;
            fwd_hit_reg <= fwd_hit_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                size_log2_reg <= cfg_wr_data;
            end
            if (state_reg == S_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        fwd_slot_reg <= slot_wdata;
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
        if (accept) begin
            mode_reg   <= s_mode;
            handle_reg <= HANDLE_WIDTH'(s_entry_value);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_popped_value = m_value_reg;

    // checks
    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_ready)
        else $error("input beat taken during clearing pass");

    a_accept_starts_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_LOOK))
        else $error("accepted beat did not start a slot lookup");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_status_reg <= STAT_SATURATED))
        else $error("status code out of range");

    a_value_zero_unless_popped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != STAT_POPPED)) |-> (m_value_reg == '0))
        else $error("popped value nonzero without a pop");

endmodule
